// ===== design/yqr_pkg.sv =====
// ----------------------------------------------------------------------------
// yqr_pkg: shared types and constants for the YUV 4:2:0 quad to RGB24 block
// Word types, fixed-point coefficients and the channel clip function.
// ----------------------------------------------------------------------------
package yqr_pkg;

   localparam int NUM_LANES     = 4;
   localparam int FRAC_BITS     = 12;
   localparam int ACC_WIDTH     = 24;
   localparam int CHAN_WIDTH    = 8;
   localparam int DIFF_WIDTH    = 10;

   localparam logic signed [DIFF_WIDTH-1:0] LUMA_OFFSET   = 10'sd16;
   localparam logic signed [DIFF_WIDTH-1:0] CHROMA_OFFSET = 10'sd128;

   localparam logic signed [ACC_WIDTH-1:0] CR_V = 24'sd5244;
   localparam logic signed [ACC_WIDTH-1:0] CG_U = 24'sd880;
   localparam logic signed [ACC_WIDTH-1:0] CG_V = 24'sd1559;
   localparam logic signed [ACC_WIDTH-1:0] CB_U = 24'sd8716;

   localparam logic [CHAN_WIDTH-1:0] CHAN_MAX = 8'd255;

   typedef logic signed [ACC_WIDTH-1:0] acc_type;

   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_top_left;
      logic [7:0] green_top_left;
      logic [7:0] blue_top_left;
      logic [7:0] red_top_right;
      logic [7:0] green_top_right;
      logic [7:0] blue_top_right;
      logic [7:0] red_bottom_left;
      logic [7:0] green_bottom_left;
      logic [7:0] blue_bottom_left;
      logic [7:0] red_bottom_right;
      logic [7:0] green_bottom_right;
      logic [7:0] blue_bottom_right;
   } rsp_word_type;

   typedef struct packed {
      acc_type red_term;
      acc_type green_term;
      acc_type blue_term;
   } chroma_terms_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
   } pixel_type;

   function automatic logic [CHAN_WIDTH-1:0] clip_channel(input acc_type acc);
      logic [CHAN_WIDTH-1:0] result;
      if (acc[ACC_WIDTH-1]) begin
         result = '0;
      end else if (|acc[ACC_WIDTH-2:FRAC_BITS+CHAN_WIDTH]) begin
         result = CHAN_MAX;
      end else begin
         result = acc[FRAC_BITS+CHAN_WIDTH-1:FRAC_BITS];
      end
      return result;
   endfunction

endpackage

// ===== design/yqr_chroma.sv =====
// ----------------------------------------------------------------------------
// yqr_chroma: shared chroma terms
// Scales the centered U and V bytes by the fixed-point coefficients once per
// word and registers the red, green and blue terms for all pixel lanes.
// ----------------------------------------------------------------------------
module yqr_chroma (
   input  logic                        clock,
   input  logic [7:0]                  chroma_u,
   input  logic [7:0]                  chroma_v,
   output yqr_pkg::chroma_terms_type   terms
);

   logic signed [yqr_pkg::DIFF_WIDTH-1:0] ud;
   logic signed [yqr_pkg::DIFF_WIDTH-1:0] vd;
   yqr_pkg::acc_type                      ud_ext;
   yqr_pkg::acc_type                      vd_ext;
   yqr_pkg::chroma_terms_type             terms_in;
   yqr_pkg::chroma_terms_type             terms_ff;

   always_comb begin
      ud     = signed'({2'b00, chroma_u}) - yqr_pkg::CHROMA_OFFSET;
      vd     = signed'({2'b00, chroma_v}) - yqr_pkg::CHROMA_OFFSET;
      ud_ext = yqr_pkg::ACC_WIDTH'(ud);
      vd_ext = yqr_pkg::ACC_WIDTH'(vd);
      terms_in.red_term   = yqr_pkg::CR_V * vd_ext;
      terms_in.green_term = -(yqr_pkg::CG_U * ud_ext) - (yqr_pkg::CG_V * vd_ext);
      terms_in.blue_term  = yqr_pkg::CB_U * ud_ext;
   end

   always_ff @(posedge clock) begin
      terms_ff <= terms_in;
   end

   assign terms = terms_ff;

endmodule

// ===== design/yqr_lane.sv =====
// ----------------------------------------------------------------------------
// yqr_lane: one pixel lane
// Adds the scaled luma to the shared chroma terms, floors, clips and
// registers one RGB24 pixel.
// ----------------------------------------------------------------------------
module yqr_lane (
   input  logic                        clock,
   input  logic [7:0]                  luma,
   input  yqr_pkg::chroma_terms_type   terms,
   output yqr_pkg::pixel_type          pixel
);

   logic signed [yqr_pkg::DIFF_WIDTH-1:0] yd;
   yqr_pkg::acc_type                      base;
   yqr_pkg::pixel_type                    pixel_in;
   yqr_pkg::pixel_type                    pixel_ff;

   always_comb begin
      yd   = signed'({2'b00, luma}) - yqr_pkg::LUMA_OFFSET;
      base = yqr_pkg::acc_type'(yqr_pkg::ACC_WIDTH'(yd) <<< yqr_pkg::FRAC_BITS);
      pixel_in.red   = yqr_pkg::clip_channel(base + terms.red_term);
      pixel_in.green = yqr_pkg::clip_channel(base + terms.green_term);
      pixel_in.blue  = yqr_pkg::clip_channel(base + terms.blue_term);
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign pixel = pixel_ff;

endmodule

// ===== design/yuv420_quad_to_rgb24_top.sv =====
// ----------------------------------------------------------------------------
// yuv420_quad_to_rgb24_top: YUV 4:2:0 2x2 block to four RGB24 pixels
// Shared chroma stage, four pixel lanes and combinational output packing.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_word with one 2x2 luma block and its U and V bytes and raise
//   start. A word is taken at every rising edge where start is high and busy
//   is low; busy stays low, so one word can enter on every clock.
//   Results leave on rsp_word, qualified by rsp_valid for exactly one cycle.
//   Throughput is one word per cycle. The chroma stage scales the chroma
//   bytes once for the block; the lane stage then runs the four pixel
//   lanes, each adding its luma, flooring and clipping its three channels.
//   Pixels are packed top-left, top-right, bottom-left, bottom-right with
//   red, green, blue in each.
//   A synchronous reset drops any words in flight; no result follows a word
//   accepted before reset. The receiver cannot stall: each result is taken
//   in the cycle it is shown.
// ----------------------------------------------------------------------------
module yuv420_quad_to_rgb24_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  yqr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output yqr_pkg::rsp_word_type rsp_word
);

   logic                                  accept;
   logic                                  stage1_valid_ff;
   logic                                  stage1_valid_in;
   logic                                  stage2_valid_ff;
   logic [yqr_pkg::NUM_LANES-1:0][7:0]    luma_in;
   logic [yqr_pkg::NUM_LANES-1:0][7:0]    luma_ff;
   yqr_pkg::chroma_terms_type             terms;
   yqr_pkg::pixel_type [yqr_pkg::NUM_LANES-1:0] pixels;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign stage1_valid_in = accept;
   assign luma_in[0]      = req_word.luma_top_left;
   assign luma_in[1]      = req_word.luma_top_right;
   assign luma_in[2]      = req_word.luma_bottom_left;
   assign luma_in[3]      = req_word.luma_bottom_right;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_valid_ff <= 1'b0;
         stage2_valid_ff <= 1'b0;
      end else begin
         stage1_valid_ff <= stage1_valid_in;
         stage2_valid_ff <= stage1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      luma_ff <= luma_in;
   end

   yqr_chroma u_chroma (
      .clock    (clock),
      .chroma_u (req_word.chroma_u),
      .chroma_v (req_word.chroma_v),
      .terms    (terms)
   );

   for (genvar lane = 0; lane < yqr_pkg::NUM_LANES; lane++) begin : g_lane
      yqr_lane u_lane (
         .clock (clock),
         .luma  (luma_ff[lane]),
         .terms (terms),
         .pixel (pixels[lane])
      );
   end

   always_comb begin
      rsp_word.red_top_left       = pixels[0].red;
      rsp_word.green_top_left     = pixels[0].green;
      rsp_word.blue_top_left      = pixels[0].blue;
      rsp_word.red_top_right      = pixels[1].red;
      rsp_word.green_top_right    = pixels[1].green;
      rsp_word.blue_top_right     = pixels[1].blue;
      rsp_word.red_bottom_left    = pixels[2].red;
      rsp_word.green_bottom_left  = pixels[2].green;
      rsp_word.blue_bottom_left   = pixels[2].blue;
      rsp_word.red_bottom_right   = pixels[3].red;
      rsp_word.green_bottom_right = pixels[3].green;
      rsp_word.blue_bottom_right  = pixels[3].blue;
   end

   assign rsp_valid = stage2_valid_ff;

`ifndef NO_ASSERTIONS
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      accept |=> stage1_valid_ff)
      else $error("accepted word did not enter the chroma stage");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !stage1_valid_ff)
      else $error("chroma stage valid without an accepted word");

   a_word_delivered : assert property (@(posedge clock) disable iff (reset)
      stage1_valid_ff |=> rsp_valid)
      else $error("word in the chroma stage was not delivered");

   a_no_extra_rsp : assert property (@(posedge clock) disable iff (reset)
      !stage1_valid_ff |=> !rsp_valid)
      else $error("result strobe without a word in flight");
`endif

endmodule
